// ===== hw/rtl/stp_pkg.sv =====
// stepper phase sequencer package: command codes, register indexes, result beat type
// and the coil pattern tables. no dependencies.
`default_nettype none

package stp_pkg;

   // command codes of a request beat
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;
   localparam logic [1:0] KIND_STOP  = 2'd3;

   // register indexes of the csr port
   localparam logic CSR_DRIVE_MODE   = 1'b0;
   localparam logic CSR_TICK_REPEATS = 1'b1;

   // drive modes
   localparam logic [1:0] MODE_FULL = 2'd0;
   localparam logic [1:0] MODE_WAVE = 2'd1;
   localparam logic [1:0] MODE_HALF = 2'd2;

   localparam int STEP_W = 31;
   localparam int TICK_W = 12;
   localparam int REP_W  = 11;

   // coil pattern bits: [3] a on, [2] a fwd, [1] b on, [0] b fwd
   localparam logic [3:0] PAT_ENABLES = 4'b1010;

   typedef struct packed {
      logic              status;
      logic [3:0]        coils;
      logic              is_stepping;
      logic [STEP_W-1:0] steps_left;
   } rsp_type;

   function automatic logic [3:0] full_pat(input logic [1:0] q);
      logic [3:0] r;
      unique case (q)
         2'd0: r = 4'hF;
         2'd1: r = 4'hE;
         2'd2: r = 4'hA;
         default: r = 4'hB;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] wave_pat(input logic [1:0] q);
      logic [3:0] r;
      unique case (q)
         2'd0: r = 4'hD;
         2'd1: r = 4'h7;
         2'd2: r = 4'h9;
         default: r = 4'h6;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] half_pat(input logic [2:0] p);
      logic [3:0] r;
      unique case (p)
         3'd0: r = 4'hD;
         3'd1: r = 4'hF;
         3'd2: r = 4'h7;
         3'd3: r = 4'hB;
         3'd4: r = 4'h9;
         3'd5: r = 4'hA;
         3'd6: r = 4'h6;
         default: r = 4'hE;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stp_out_buf.sv =====
// two-entry result buffer (output register plus skid stage) for the rsp channel.
// depends on stp_pkg for the result beat type.
`default_nettype none

module stp_out_buf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire stp_pkg::rsp_type in_data,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output stp_pkg::rsp_type      out_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   stp_pkg::rsp_type out_ff, out_in;
   stp_pkg::rsp_type skid_ff, skid_in;
   logic             take;
   logic             accept;

   assign take      = out_valid_ff & ~out_stall;
   assign accept    = in_valid & ~skid_valid_ff;
   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = accept;
            skid_in       = in_data;
         end else begin
            out_valid_in = accept;
            out_in       = in_data;
         end
      end else if (!out_valid_ff) begin
         out_valid_in = accept;
         out_in       = in_data;
      end else if (accept) begin
         // result still waiting, park the new beat in the skid stage
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/stepper_phase_sequencer.sv =====
// top level of the bipolar stepper phase sequencer: command decode, step state and
// coil sequencing. depends on stp_pkg and stp_out_buf.
//
// usage:
//   req channel (req_valid / req_stall) carries one command beat: tick, load steps,
//   start or stop. rsp channel (rsp_valid / rsp_stall) returns exactly one result
//   beat per command: status, the held coil pattern, stepping flag and steps left.
//   the csr port (csr_write, csr_index, csr_data) sets drive mode and tick repeats;
//   write it only while no command is in flight.
//   the result of an accepted command is registered in the output buffer.
//   throughput: one command per cycle while req_stall is low; the state update is
//   a single registered pass. a two-entry output buffer lets one more command in
//   while a result waits; req_stall is high whenever both entries are full.
//   reset (synchronous, active high) returns to ready, phase 0, forward, zero
//   steps, tick count 0, all coil pattern bits set, csr registers 0, and empties
//   the output buffer.
`default_nettype none

module stepper_phase_sequencer #(
   parameter int COUNT_BITS = 31
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write,
   input  wire logic                       csr_index,
   input  wire logic [stp_pkg::REP_W-1:0]  csr_data,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_kind,
   input  wire logic                       req_move_reverse,
   input  wire logic [stp_pkg::STEP_W-1:0] req_step_total,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_status,
   output logic                            rsp_coil_a_on,
   output logic                            rsp_coil_a_fwd,
   output logic                            rsp_coil_b_on,
   output logic                            rsp_coil_b_fwd,
   output logic                            rsp_is_stepping,
   output logic [stp_pkg::STEP_W-1:0]      rsp_steps_left
);

   typedef enum logic [1:0] {
      RS_READY    = 2'd0,
      RS_STEPPING = 2'd1,
      RS_HALTED   = 2'd2
   } run_state_type;

   localparam logic [stp_pkg::STEP_W-1:0] CountMax =
      stp_pkg::STEP_W'((64'd1 << COUNT_BITS) - 64'd1);

   logic [1:0]                   drive_mode_ff;
   logic [stp_pkg::REP_W-1:0]    tick_repeats_ff;
   run_state_type                run_state_ff, run_state_in;
   logic [2:0]                   phase_ff, phase_in;
   logic                         reverse_ff, reverse_in;
   logic [COUNT_BITS-1:0]        remaining_ff, remaining_in;
   logic [stp_pkg::TICK_W-1:0]   tick_count_ff, tick_count_in;
   logic [3:0]                   coils_ff, coils_in;

   logic                         accept;
   logic                         buf_stall;
   logic                         status;
   logic [stp_pkg::TICK_W-1:0]   tick_next;
   logic [1:0]                   q;
   stp_pkg::rsp_type             rsp_in;
   stp_pkg::rsp_type             rsp_out;

   assign accept    = req_valid & ~buf_stall;
   assign req_stall = buf_stall;

   always_comb begin
      run_state_in  = run_state_ff;
      phase_in      = phase_ff;
      reverse_in    = reverse_ff;
      remaining_in  = remaining_ff;
      tick_count_in = tick_count_ff;
      coils_in      = coils_ff;
      status        = 1'b0;
      tick_next     = tick_count_ff + 1'b1;
      q             = (phase_ff > 3'd3) ? 2'd3 : phase_ff[1:0];
      unique case (req_kind)
         stp_pkg::KIND_TICK: begin
            tick_count_in = tick_next;
            if (tick_next > {1'b0, tick_repeats_ff}) begin
               tick_count_in = '0;
               if (run_state_ff == RS_STEPPING) begin
                  if (remaining_ff <= COUNT_BITS'(1)) begin
                     remaining_in = '0;
                     run_state_in = RS_HALTED;
                     coils_in     = coils_ff & ~stp_pkg::PAT_ENABLES;
                  end else begin
                     remaining_in = remaining_ff - 1'b1;
                     if (drive_mode_ff == stp_pkg::MODE_HALF) begin
                        coils_in = stp_pkg::half_pat(phase_ff);
                        phase_in = reverse_ff ? phase_ff - 1'b1 : phase_ff + 1'b1;
                     end else begin
                        coils_in = (drive_mode_ff == stp_pkg::MODE_WAVE) ?
                                   stp_pkg::wave_pat(q) : stp_pkg::full_pat(q);
                        phase_in = {1'b0, (reverse_ff ? q - 1'b1 : q + 1'b1)};
                     end
                  end
               end
            end
         end
         stp_pkg::KIND_LOAD: begin
            if (req_step_total == '0) begin
               status = 1'b1;
            end else begin
               reverse_in   = req_move_reverse;
               remaining_in = (req_step_total > CountMax) ? CountMax[COUNT_BITS-1:0]
                                                         : req_step_total[COUNT_BITS-1:0];
            end
         end
         stp_pkg::KIND_START: begin
            if (remaining_ff == '0 || run_state_ff == RS_STEPPING) begin
               status = 1'b1;
            end else begin
               run_state_in = RS_STEPPING;
               coils_in     = coils_ff | stp_pkg::PAT_ENABLES;
            end
         end
         default: begin
            if (run_state_ff == RS_HALTED) begin
               status = 1'b1;
            end else begin
               run_state_in = RS_HALTED;
               coils_in     = coils_ff & ~stp_pkg::PAT_ENABLES;
            end
         end
      endcase
      rsp_in.status      = status;
      rsp_in.coils       = coils_in;
      rsp_in.is_stepping = (run_state_in == RS_STEPPING);
      rsp_in.steps_left  = stp_pkg::STEP_W'(remaining_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_mode_ff   <= stp_pkg::MODE_FULL;
         tick_repeats_ff <= '0;
         run_state_ff    <= RS_READY;
         phase_ff        <= '0;
         reverse_ff      <= 1'b0;
         remaining_ff    <= '0;
         tick_count_ff   <= '0;
         coils_ff        <= 4'hF;
      end else begin
         if (csr_write) begin
            if (csr_index == stp_pkg::CSR_DRIVE_MODE) begin
               drive_mode_ff <= csr_data[1:0];
            end else begin
               tick_repeats_ff <= csr_data;
            end
         end
         if (accept) begin
            run_state_ff  <= run_state_in;
            phase_ff      <= phase_in;
            reverse_ff    <= reverse_in;
            remaining_ff  <= remaining_in;
            tick_count_ff <= tick_count_in;
            coils_ff      <= coils_in;
         end
      end
   end

   stp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (buf_stall),
      .in_data   (rsp_in),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_out)
   );

   assign rsp_status      = rsp_out.status;
   assign rsp_coil_a_on   = rsp_out.coils[3];
   assign rsp_coil_a_fwd  = rsp_out.coils[2];
   assign rsp_coil_b_on   = rsp_out.coils[1];
   assign rsp_coil_b_fwd  = rsp_out.coils[0];
   assign rsp_is_stepping = rsp_out.is_stepping;
   assign rsp_steps_left  = rsp_out.steps_left;

endmodule

`default_nettype wire

// ===== dv/stepper_phase_sequencer_checker.sv =====
// checker for the stepper phase sequencer: watches the csr port and both beat channels,
// predicts each result beat from its own copy of the sequencer state and compares.
// depends on stp_pkg for command codes, register indexes and the result beat type.
`default_nettype none

module stepper_phase_sequencer_checker #(
   parameter int COUNT_BITS = 31
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write,
   input  wire logic                       csr_index,
   input  wire logic [stp_pkg::REP_W-1:0]  csr_data,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic [1:0]                 req_kind,
   input  wire logic                       req_move_reverse,
   input  wire logic [stp_pkg::STEP_W-1:0] req_step_total,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic                       rsp_status,
   input  wire logic                       rsp_coil_a_on,
   input  wire logic                       rsp_coil_a_fwd,
   input  wire logic                       rsp_coil_b_on,
   input  wire logic                       rsp_coil_b_fwd,
   input  wire logic                       rsp_is_stepping,
   input  wire logic [stp_pkg::STEP_W-1:0] rsp_steps_left,
   output int                              mismatches,
   output int                              outstanding,
   output int                              results_checked,
   output int                              rejects,
   output int                              step_events
);

   typedef enum logic [1:0] {RUN_READY, RUN_STEPPING, RUN_HALTED} run_state_type;

   typedef logic [stp_pkg::STEP_W-1:0] field_type;

   localparam field_type COUNT_LIMIT = field_type'((64'd1 << COUNT_BITS) - 64'd1);

   // coil sequences, entry 0 in the low nibble
   localparam logic [15:0] FULL_SEQ = {4'hB, 4'hA, 4'hE, 4'hF};
   localparam logic [15:0] WAVE_SEQ = {4'h6, 4'h9, 4'h7, 4'hD};
   localparam logic [31:0] HALF_SEQ = {4'hE, 4'h6, 4'hA, 4'h9, 4'hB, 4'h7, 4'hF, 4'hD};

   logic [1:0]                 drive_mode;
   logic [stp_pkg::REP_W-1:0]  tick_repeats;
   run_state_type              run;
   logic [2:0]                 coil_phase;
   logic                       reverse;
   field_type                  left;
   logic [stp_pkg::TICK_W-1:0] tick_count;
   logic [3:0]                 coils;

   stp_pkg::rsp_type due_results[$];

   function automatic void move_coils();
      logic [2:0] p;
      logic [1:0] q;
      p = coil_phase;
      if (drive_mode == stp_pkg::MODE_HALF) begin
         coils = HALF_SEQ[p*4 +: 4];
         coil_phase = reverse ? p - 3'd1 : p + 3'd1;
      end else begin
         // upper half-step phases fold onto the last full/wave pattern
         q = (p > 3'd3) ? 2'd3 : p[1:0];
         coils = (drive_mode == stp_pkg::MODE_WAVE) ? WAVE_SEQ[q*4 +: 4] : FULL_SEQ[q*4 +: 4];
         coil_phase = {1'b0, (reverse ? q - 2'd1 : q + 2'd1)};
      end
   endfunction

   function automatic void take_step();
      if (run == RUN_STEPPING) begin
         step_events++;
         if (left <= 1) begin
            left = '0;
            run = RUN_HALTED;
            coils = coils & ~stp_pkg::PAT_ENABLES;
         end else begin
            left = left - 1'b1;
            move_coils();
         end
      end
   endfunction

   function automatic stp_pkg::rsp_type apply_command(input logic [1:0] kind,
                                                      input logic rev,
                                                      input field_type total);
      stp_pkg::rsp_type r;
      logic             bad;
      bad = 1'b0;
      case (kind)
         stp_pkg::KIND_TICK: begin
            tick_count = tick_count + 1'b1;
            if (tick_count > {1'b0, tick_repeats}) begin
               tick_count = '0;
               take_step();
            end
         end
         stp_pkg::KIND_LOAD: begin
            if (total == '0) begin
               bad = 1'b1;
            end else begin
               reverse = rev;
               left = (total > COUNT_LIMIT) ? COUNT_LIMIT : total;
            end
         end
         stp_pkg::KIND_START: begin
            if (left == '0 || run == RUN_STEPPING) begin
               bad = 1'b1;
            end else begin
               run = RUN_STEPPING;
               coils = coils | stp_pkg::PAT_ENABLES;
            end
         end
         default: begin
            if (run == RUN_HALTED) begin
               bad = 1'b1;
            end else begin
               run = RUN_HALTED;
               coils = coils & ~stp_pkg::PAT_ENABLES;
            end
         end
      endcase
      if (bad) rejects++;
      r.status      = bad;
      r.coils       = coils;
      r.is_stepping = (run == RUN_STEPPING);
      r.steps_left  = left;
      return r;
   endfunction

   function automatic void check_field(input string name, input field_type want,
                                       input field_type got);
      if (got !== want) begin
         if (mismatches < 10)
            $display("result %0d %s: expected %0h, got %0h", results_checked, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      stp_pkg::rsp_type want;
      if (reset) begin
         drive_mode      = stp_pkg::MODE_FULL;
         tick_repeats    = '0;
         run             = RUN_READY;
         coil_phase      = '0;
         reverse         = 1'b0;
         left            = '0;
         tick_count      = '0;
         coils           = 4'hF;
         mismatches      = 0;
         results_checked = 0;
         rejects         = 0;
         step_events     = 0;
         due_results.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == stp_pkg::CSR_DRIVE_MODE) drive_mode = csr_data[1:0];
            else tick_repeats = csr_data;
         end
         // compare before pushing so a beat with nothing owed is caught
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (due_results.size() == 0) begin
               if (mismatches < 10)
                  $display("result %0d arrived with no command outstanding", results_checked);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               check_field("status", field_type'(want.status), field_type'(rsp_status));
               check_field("coil_a_on", field_type'(want.coils[3]),
                           field_type'(rsp_coil_a_on));
               check_field("coil_a_fwd", field_type'(want.coils[2]),
                           field_type'(rsp_coil_a_fwd));
               check_field("coil_b_on", field_type'(want.coils[1]),
                           field_type'(rsp_coil_b_on));
               check_field("coil_b_fwd", field_type'(want.coils[0]),
                           field_type'(rsp_coil_b_fwd));
               check_field("is_stepping", field_type'(want.is_stepping),
                           field_type'(rsp_is_stepping));
               check_field("steps_left", want.steps_left, rsp_steps_left);
            end
         end
         if (req_valid && !req_stall)
            due_results.push_back(apply_command(req_kind, req_move_reverse, req_step_total));
      end
      outstanding <= due_results.size();
   end

endmodule

`default_nettype wire

// ===== dv/stepper_phase_sequencer_tb.sv =====
// testbench top for the stepper phase sequencer: clock, reset, csr setup and command
// stimulus over several drive settings and idle patterns, plus the verdict.
// depends on stp_pkg, stepper_phase_sequencer and stepper_phase_sequencer_checker.
`default_nettype none

module stepper_phase_sequencer_tb;

   localparam int         QUIET_LIMIT = 1000;
   localparam int         PHASES      = 11;
   localparam int         PHASE_CMDS  = 50;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         csr_write        = 1'b0;
   logic                         csr_index        = stp_pkg::CSR_DRIVE_MODE;
   logic [stp_pkg::REP_W-1:0]    csr_data         = '0;
   logic                         req_valid        = 1'b0;
   logic [1:0]                   req_kind         = stp_pkg::KIND_TICK;
   logic                         req_move_reverse = 1'b0;
   logic [stp_pkg::STEP_W-1:0]   req_step_total   = '0;
   logic                         rsp_stall        = 1'b0;
   logic                         req_stall;
   logic                         rsp_valid;
   logic                         rsp_status;
   logic                         rsp_coil_a_on;
   logic                         rsp_coil_a_fwd;
   logic                         rsp_coil_b_on;
   logic                         rsp_coil_b_fwd;
   logic                         rsp_is_stepping;
   logic [stp_pkg::STEP_W-1:0]   rsp_steps_left;

   int mismatches;
   int outstanding;
   int results_checked;
   int rejects;
   int step_events;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int sent          = 0;

   stepper_phase_sequencer DUT (.*);

   stepper_phase_sequencer_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic logic [stp_pkg::STEP_W-1:0] rand_word();
      return stp_pkg::STEP_W'($urandom);
   endfunction

   // one command beat; valid stays up across back-to-back beats
   task automatic send_cmd(input logic [1:0] kind, input logic rev,
                           input logic [stp_pkg::STEP_W-1:0] total);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_move_reverse <= rev;
      req_step_total   <= total;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding > 0) @(posedge clock);
   endtask

   task automatic configure(input logic [1:0] mode, input logic [stp_pkg::REP_W-1:0] rep,
                            input int idle_pct, input int stall);
      csr_write <= 1'b1;
      csr_index <= stp_pkg::CSR_DRIVE_MODE;
      csr_data  <= stp_pkg::REP_W'(mode);
      @(posedge clock);
      csr_index <= stp_pkg::CSR_TICK_REPEATS;
      csr_data  <= rep;
      @(posedge clock);
      csr_write <= 1'b0;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
   endtask

   // mostly short moves so they run out, now and then a wide count
   function automatic logic [stp_pkg::STEP_W-1:0] pick_total();
      int r;
      r = $urandom_range(99);
      if (r < 70) return stp_pkg::STEP_W'($urandom_range(12, 1));
      if (r < 85) return stp_pkg::STEP_W'($urandom_range(300, 13));
      return stp_pkg::STEP_W'($urandom) >> $urandom_range(30);
   endfunction

   task automatic run_move(input int rep);
      logic [stp_pkg::STEP_W-1:0] total;
      int                         span;
      int                         ticks;
      total = pick_total();
      send_cmd(stp_pkg::KIND_LOAD, rand_bit(), total);
      if ($urandom_range(9) == 0) send_cmd(stp_pkg::KIND_STOP, rand_bit(), rand_word());
      send_cmd(stp_pkg::KIND_START, rand_bit(), rand_word());
      span  = (total > 8) ? 8 : int'(total);
      ticks = (rep > 16) ? rep + 3 : span * (rep + 1) + $urandom_range(2);
      repeat (ticks) begin
         // slow rates run one uninterrupted move so a step event is reached
         case ((rep > 16) ? 59 : $urandom_range(59))
            0:       send_cmd(stp_pkg::KIND_LOAD, rand_bit(), pick_total());
            1:       send_cmd(stp_pkg::KIND_START, rand_bit(), rand_word());
            2:       send_cmd(stp_pkg::KIND_STOP, rand_bit(), rand_word());
            default: send_cmd(stp_pkg::KIND_TICK, rand_bit(), rand_word());
         endcase
      end
      if ($urandom_range(1)) send_cmd(stp_pkg::KIND_STOP, rand_bit(), rand_word());
   endtask

   task automatic send_noise();
      send_cmd(2'($urandom_range(3)), rand_bit(),
               ($urandom_range(3) == 0) ? '0 : rand_word());
   endtask

   task automatic random_phase(input int target, input int rep);
      int first;
      first = sent;
      while (sent - first < target) begin
         if ($urandom_range(99) < 75) run_move(rep);
         else send_noise();
      end
   endtask

   task automatic directed_cmds();
      send_cmd(stp_pkg::KIND_START, 1'b0, '0);            // nothing loaded yet
      send_cmd(stp_pkg::KIND_TICK, 1'b1, '1);             // tick while ready
      send_cmd(stp_pkg::KIND_STOP, 1'b0, '0);             // ready to halted
      send_cmd(stp_pkg::KIND_STOP, 1'b1, '1);             // already halted
      send_cmd(stp_pkg::KIND_LOAD, 1'b1, '0);             // zero count
      send_cmd(stp_pkg::KIND_LOAD, 1'b0, '1);             // largest count
      send_cmd(stp_pkg::KIND_START, 1'b0, '0);
      send_cmd(stp_pkg::KIND_START, 1'b0, '0);            // already stepping
      send_cmd(stp_pkg::KIND_LOAD, 1'b1, stp_pkg::STEP_W'(3)); // reload mid-move, reverse
      repeat (4) send_cmd(stp_pkg::KIND_TICK, 1'b0, '0);  // two steps, halt, tick while halted
      send_cmd(stp_pkg::KIND_START, 1'b0, '0);            // halted with nothing left
      send_cmd(stp_pkg::KIND_LOAD, 1'b0, 31'h2AAA_AAAA);
      send_cmd(stp_pkg::KIND_LOAD, 1'b1, 31'h5555_5555);
      send_cmd(stp_pkg::KIND_START, 1'b1, '1);
      repeat (3) send_cmd(stp_pkg::KIND_TICK, 1'b1, '1);
      send_cmd(stp_pkg::KIND_STOP, 1'b0, '0);             // stop while stepping
      send_cmd(stp_pkg::KIND_LOAD, 1'b0, stp_pkg::STEP_W'(1));
      send_cmd(stp_pkg::KIND_START, 1'b0, '0);
      send_cmd(stp_pkg::KIND_TICK, 1'b0, '0);             // last step halts at once
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < PHASES; i++) begin
         case (i)
            0:  configure(stp_pkg::MODE_FULL, 11'd0, 0, 0);
            1:  configure(stp_pkg::MODE_FULL, 11'd0, 0, 0);
            2:  configure(stp_pkg::MODE_WAVE, 11'd1, 63, 0);
            3:  configure(stp_pkg::MODE_HALF, 11'd0, 0, 63);
            4:  configure(stp_pkg::MODE_FULL, 11'd2, 27, 27);
            5:  configure(stp_pkg::MODE_HALF, 11'd3, 0, 0);
            6:  configure(MODE_SPARE, 11'd0, 63, 0);
            7:  configure(stp_pkg::MODE_WAVE, 11'd0, 0, 63);
            8:  configure(stp_pkg::MODE_HALF, 11'd1, 27, 27);
            9:  configure(stp_pkg::MODE_FULL, 11'd100, 0, 0);
            default: configure(stp_pkg::MODE_HALF, 11'd0, 27, 27);
         endcase
         if (i == 0) directed_cmds();
         else random_phase(PHASE_CMDS, int'(csr_data));
         drain();
      end
      repeat (4) @(posedge clock);
      $display("covered %0d commands over %0d drive and rate settings, all mode codes,",
               sent, PHASES);
      $display("tick repeats 0 to 100: %0d results checked, %0d rejected, %0d step events",
               results_checked, rejects, step_events);
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
